[rtl/core/tccur_pkg.sv]
// Shared types and constants of the text console cursor engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tccur_pkg;

   // result command codes
   typedef enum logic [1:0] {
      ACT_DRAW   = 2'd0,
      ACT_SCROLL = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   // request op codes
   typedef enum logic {
      OP_CHAR  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_ENABLE  = 2'd0,
      CSR_COLUMNS = 2'd1,
      CSR_ROWS    = 2'd2
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [8:0] COLUMNS_RESET = 9'd80;
   localparam logic [8:0] ROWS_RESET    = 9'd25;

   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_PRINT_MAX = 8'h7E;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [7:0] glyph_code;
      logic [7:0] cell_column;
      logic [7:0] cell_row;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       enabled;
      logic [8:0] columns;
      logic [8:0] rows;
   } cfg_type;

   // up to two commands caused by one item, in delivery order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } cmd_pair_type;

endpackage

`default_nettype wire

[rtl/core/tccur_cursor.sv]
// Cursor column/row registers and the per-item command decode.
// Depends on tccur_pkg.
`default_nettype none

module tccur_cursor
   import tccur_pkg::*;
#(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  req_type      item,
   input  cfg_type      cfg,
   output cmd_pair_type cmds
);

   localparam logic [8:0] MAX_COLS_W = 9'(MAX_COLUMNS);
   localparam logic [8:0] MAX_ROWS_W = 9'(MAX_ROWS);

   logic [7:0] column_ff, column_in;
   logic [7:0] row_ff, row_in;

   logic [8:0] cols_eff, rows_eff;
   logic [8:0] col_inc, row_inc;
   logic       wrap, scroll_need, printable;
   logic [7:0] row_next;
   rsp_type    draw_cmd, scroll_cmd, clear_cmd, erase_cmd;

   always_comb begin
      // clamp sizes: zero acts as one, oversize as the maximum
      if (cfg.columns == 9'd0) begin
         cols_eff = 9'd1;
      end else if (cfg.columns > MAX_COLS_W) begin
         cols_eff = MAX_COLS_W;
      end else begin
         cols_eff = cfg.columns;
      end
      if (cfg.rows == 9'd0) begin
         rows_eff = 9'd1;
      end else if (cfg.rows > MAX_ROWS_W) begin
         rows_eff = MAX_ROWS_W;
      end else begin
         rows_eff = cfg.rows;
      end

      col_inc     = {1'b0, column_ff} + 9'd1;
      row_inc     = {1'b0, row_ff} + 9'd1;
      wrap        = (col_inc >= cols_eff);
      scroll_need = (row_inc >= rows_eff);
      row_next    = scroll_need ? 8'(rows_eff - 9'd1) : row_inc[7:0];
      printable   = (item.char_code >= CHAR_SPACE) && (item.char_code <= CHAR_PRINT_MAX);

      draw_cmd   = '{ACT_DRAW, item.char_code, column_ff, row_ff, 1'b0};
      erase_cmd  = '{ACT_DRAW, CHAR_SPACE, column_ff - 8'd1, row_ff, 1'b1};
      scroll_cmd = '{ACT_SCROLL, 8'd0, 8'd0, 8'd0, 1'b1};
      clear_cmd  = '{ACT_CLEAR, 8'd0, 8'd0, 8'd0, 1'b1};
   end

   always_comb begin
      column_in   = column_ff;
      row_in      = row_ff;
      cmds.count  = 2'd0;
      cmds.first  = scroll_cmd;
      cmds.second = scroll_cmd;
      if (take && cfg.enabled) begin
         priority if (item.op == OP_CLEAR) begin
            column_in  = 8'd0;
            row_in     = 8'd0;
            cmds.count = 2'd1;
            cmds.first = clear_cmd;
         end else if (item.char_code == CHAR_CR) begin
            column_in = 8'd0;
         end else if (item.char_code == CHAR_LF) begin
            column_in  = 8'd0;
            row_in     = row_next;
            cmds.count = {1'b0, scroll_need};
         end else if (item.char_code == CHAR_BS) begin
            if (column_ff != 8'd0) begin
               column_in  = column_ff - 8'd1;
               cmds.count = 2'd1;
               cmds.first = erase_cmd;
            end
         end else begin
            // draw (if printable) then advance, wrapping and scrolling
            if (wrap) begin
               column_in = 8'd0;
               row_in    = row_next;
            end else begin
               column_in = col_inc[7:0];
            end
            if (printable) begin
               cmds.first      = draw_cmd;
               cmds.first.last = !(wrap && scroll_need);
            end
            cmds.count = 2'({1'b0, printable} + {1'b0, wrap && scroll_need});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
         row_ff    <= 8'd0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/tccur_rsp_buf.sv]
// Two-slot result register that holds the commands of one item for delivery.
// Depends on tccur_pkg.
`default_nettype none

module tccur_rsp_buf
   import tccur_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_pair_type cmds,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign pop       = rsp_valid && !rsp_stall;
   // take a new item only when every held command leaves this cycle
   assign room      = (count_ff == 2'd0) || ((count_ff == 2'd1) && !rsp_stall);

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push) begin
         count_in = cmds.count;
         head_in  = cmds.first;
         tail_in  = cmds.second;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         head_in  = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

[rtl/core/text_console_cursor_engine.sv]
// Top level of the text console cursor engine: configuration registers,
// cursor decode and result buffer. Depends on tccur_pkg, tccur_cursor, tccur_rsp_buf.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall    req_data  (req_type: op, char_code)
//   rsp_     out        rsp_valid/rsp_stall    rsp_data  (rsp_type: action..last)
//   csr_     in         csr_we                 csr_index, csr_wdata
//
// Cycles: an item is decoded in the cycle it is accepted; its commands appear
// on rsp_ the next cycle. One item per cycle is taken while each item causes at
// most one command and rsp_ is not stalled; an item that causes two holds off req_
// until the single result port has handed out the first of its two commands.
// Reset: synchronous, clears the cursor to (0,0), the result register and the
// configuration to disabled, 80 columns, 25 rows.
// Stalls: req_stall is high while the result register cannot empty this cycle.
`default_nettype none

module text_console_cursor_engine
   import tccur_pkg::*;
#(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   cmd_pair_type cmds;
   logic         room;
   logic         take;

   // accept when the result register will be empty after this edge
   assign req_stall = !room;
   assign take      = req_valid && room;

   // configuration writes; unused indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:  cfg_in.enabled = csr_wdata[0];
            CSR_COLUMNS: cfg_in.columns = csr_wdata;
            CSR_ROWS:    cfg_in.rows    = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{1'b0, COLUMNS_RESET, ROWS_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode the item against the cursor and advance the cursor
   tccur_cursor #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS   (MAX_ROWS)
   ) u_cursor (
      .clock(clock),
      .reset(reset),
      .take (take),
      .item (req_data),
      .cfg  (cfg_ff),
      .cmds (cmds)
   );

   // hold the item's commands and hand them out one per cycle while rsp_stall is low
   tccur_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .cmds     (cmds),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/tccur_checker.sv]
// Port-level checks for the text console cursor engine, bound to the top level.
// Depends on tccur_pkg.
`default_nettype none

module tccur_checker
   import tccur_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled command holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // no undefined command code leaves the block
   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.action == ACT_DRAW || rsp_data.action == ACT_SCROLL ||
                     rsp_data.action == ACT_CLEAR))
      else $error("bad action code");

   // scroll and clear carry zero cell fields
   a_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_DRAW |->
         rsp_data.glyph_code == 8'd0 && rsp_data.cell_column == 8'd0 &&
         rsp_data.cell_row == 8'd0)
      else $error("scroll/clear with nonzero cell fields");

   // scroll and clear always end an item's commands
   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_DRAW |-> rsp_data.last)
      else $error("scroll/clear without last");

   // a non-final draw is followed by a scroll
   a_draw_then_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=>
         rsp_valid && rsp_data.action == ACT_SCROLL)
      else $error("non-final draw not followed by scroll");

endmodule

bind text_console_cursor_engine tccur_checker u_tccur_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire

[dv/text_console_cursor_engine_tb.sv]
// Self-checking testbench for text_console_cursor_engine: drives character and clear items,
// predicts the draw, scroll and clear commands in a scoreboard class, and checks every result.
// Depends on tccur_pkg and the engine RTL only.
`timescale 1ns / 100ps

module text_console_cursor_engine_tb;
   import tccur_pkg::*;

   localparam int COLUMN_LIMIT = 256;
   localparam int ROW_LIMIT    = 256;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 4;
   localparam int REPORT_CAP   = 60;

   // flavors of random character streams
   typedef enum int {
      MIX_TEXT,
      MIX_LONG_LINE,
      MIX_TALL,
      MIX_NOISE
   } mix_type;

   // Scoreboard: keeps its own copy of the registers and the cursor, works out the
   // commands each accepted item causes and checks the results in order.
   class cursor_scoreboard;
      logic       enabled;
      logic [8:0] columns;
      logic [8:0] rows;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
      rsp_type    commands_due[$];
      int         errors;
      int         reported;

      function new();
         enabled    = 1'b0;
         columns    = COLUMNS_RESET;
         rows       = ROWS_RESET;
         cursor_col = 8'h00;
         cursor_row = 8'h00;
         errors     = 0;
         reported   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [8:0] value);
         case (idx)
            CSR_ENABLE:  enabled = value[0];
            CSR_COLUMNS: columns = value;
            CSR_ROWS:    rows = value;
            default: ;
         endcase
      endfunction

      // zero acts as one, anything past the limit acts as the limit
      function int screen_size(logic [8:0] value, int limit);
         if (value == 9'd0) return 1;
         if (int'(value) > limit) return limit;
         return int'(value);
      endfunction

      // move down one row; report whether the screen has to scroll
      function bit step_row();
         int height;
         height = screen_size(rows, ROW_LIMIT);
         if (int'(cursor_row) + 1 >= height) begin
            cursor_row = 8'(height - 1);
            return 1'b1;
         end
         cursor_row = cursor_row + 8'd1;
         return 1'b0;
      endfunction

      function rsp_type make_cmd(action_type act, logic [7:0] glyph, logic [7:0] col,
                                 logic [7:0] row);
         rsp_type cmd;
         cmd.action      = act;
         cmd.glyph_code  = glyph;
         cmd.cell_column = col;
         cmd.cell_row    = row;
         cmd.last        = 1'b0;
         return cmd;
      endfunction

      // predict the commands of one accepted item
      function void accept_item(req_type item);
         rsp_type cmds[$];
         int width;
         if (!enabled) return;
         if (item.op == OP_CLEAR) begin
            cursor_col = 8'h00;
            cursor_row = 8'h00;
            cmds.push_back(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 8'h00));
         end else if (item.char_code == CHAR_CR) begin
            cursor_col = 8'h00;
         end else if (item.char_code == CHAR_LF) begin
            cursor_col = 8'h00;
            if (step_row()) cmds.push_back(make_cmd(ACT_SCROLL, 8'h00, 8'h00, 8'h00));
         end else if (item.char_code == CHAR_BS) begin
            if (cursor_col != 8'h00) begin
               cursor_col = cursor_col - 8'd1;
               cmds.push_back(make_cmd(ACT_DRAW, CHAR_SPACE, cursor_col, cursor_row));
            end
         end else begin
            if (item.char_code >= CHAR_SPACE && item.char_code <= CHAR_PRINT_MAX)
               cmds.push_back(make_cmd(ACT_DRAW, item.char_code, cursor_col, cursor_row));
            width = screen_size(columns, COLUMN_LIMIT);
            if (int'(cursor_col) + 1 >= width) begin
               cursor_col = 8'h00;
               if (step_row()) cmds.push_back(make_cmd(ACT_SCROLL, 8'h00, 8'h00, 8'h00));
            end else begin
               cursor_col = cursor_col + 8'd1;
            end
         end
         if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
         foreach (cmds[i]) commands_due.push_back(cmds[i]);
      endfunction

      function void note_error(string what, logic [7:0] want, logic [7:0] got);
         errors++;
         if (reported < REPORT_CAP) begin
            reported++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
         end
      endfunction

      function void check_command(rsp_type got);
         rsp_type want;
         if (commands_due.size() == 0) begin
            note_error("unexpected command", 8'h00, 8'(got.action));
            return;
         end
         want = commands_due.pop_front();
         if (got.action !== want.action) note_error("action", 8'(want.action), 8'(got.action));
         if (got.glyph_code !== want.glyph_code)
            note_error("glyph_code", want.glyph_code, got.glyph_code);
         if (got.cell_column !== want.cell_column)
            note_error("cell_column", want.cell_column, got.cell_column);
         if (got.cell_row !== want.cell_row)
            note_error("cell_row", want.cell_row, got.cell_row);
         if (got.last !== want.last) note_error("last", 8'(want.last), 8'(got.last));
      endfunction

      function int pending();
         return commands_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cursor_scoreboard sb;
   int               hold_request;
   int               cycle_count;

   text_console_cursor_engine #(
      .MAX_COLUMNS(COLUMN_LIMIT),
      .MAX_ROWS(ROW_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Every task below starts and ends at a falling edge, so each input gets
   // at most one nonblocking update per time step.

   // offer one item and hold it until accepted; stall is sampled before the edge settles
   task automatic send_item(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.accept_item(item);
      @(negedge clock);
   endtask

   // drop valid for a gap; a zero gap leaves valid alone so the burst goes on
   task automatic idle_sender(int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // drop valid, let every due command drain, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [8:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   // write all three registers back to back; only called with the engine idle
   task automatic set_config(logic enable, logic [8:0] cols, logic [8:0] height);
      write_reg(CSR_ENABLE, {8'h00, enable});
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS, height);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type make_item(op_type op, logic [7:0] code);
      req_type item;
      item.op        = op;
      item.char_code = code;
      return item;
   endfunction

   // mostly small screens, now and then the edges and oversize values
   function automatic logic [8:0] random_size();
      case ($urandom_range(0, 9))
         0:       return 9'd0;
         1:       return 9'd1;
         7:       return 9'($urandom_range(13, 255));
         8:       return 9'd256;
         9:       return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(2, 12));
      endcase
   endfunction

   function automatic req_type random_item(mix_type mix);
      int pick;
      pick = $urandom_range(0, 99);
      case (mix)
         MIX_LONG_LINE: begin
            // long runs of printable text push the column toward its top bits
            if (pick < 96) return make_item(OP_CHAR, 8'($urandom_range(CHAR_SPACE, CHAR_PRINT_MAX)));
            if (pick < 98) return make_item(OP_CHAR, CHAR_BS);
            return make_item(OP_CHAR, 8'($urandom_range(8'h7F, 8'hFF)));
         end
         MIX_TALL: begin
            // mostly line feeds to walk the row down, with draws along the way
            if (pick < 92) return make_item(OP_CHAR, CHAR_LF);
            return make_item(OP_CHAR, 8'($urandom_range(CHAR_SPACE, CHAR_PRINT_MAX)));
         end
         MIX_NOISE: begin
            if (pick < 10) return make_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            return make_item(OP_CHAR, 8'($urandom_range(0, 255)));
         end
         default: begin
            if (pick < 2)  return make_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            if (pick < 50) return make_item(OP_CHAR, 8'($urandom_range(CHAR_SPACE, CHAR_PRINT_MAX)));
            if (pick < 62) return make_item(OP_CHAR, CHAR_LF);
            if (pick < 70) return make_item(OP_CHAR, CHAR_CR);
            if (pick < 80) return make_item(OP_CHAR, CHAR_BS);
            if (pick < 90) return make_item(OP_CHAR, 8'($urandom_range(0, 8'h1F)));
            return make_item(OP_CHAR, 8'($urandom_range(8'h7F, 8'hFF)));
         end
      endcase
   endfunction

   // send items in bursts of random length; gap_max of zero keeps valid up throughout
   task automatic drive_items(int count, mix_type mix, int gap_max);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            if (gap_max > 0) idle_sender($urandom_range(0, gap_max));
         end
         send_item(random_item(mix));
         burst--;
      end
   endtask

   // Receiver: pick a stall pattern for a random span of cycles, and honor a
   // long hold once when asked, counting it down here.
   initial begin
      int mode;
      int span;
      int hold_left;
      bit hold_taken;
      rsp_stall  = 1'b0;
      mode       = 0;
      span       = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0 && !hold_taken) begin
            hold_left  = hold_request;
            hold_taken = 1'b1;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (span % 3 == 0);
            endcase
         end
      end
   end

   // check every result taken at the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_command(rsp_data);
   end

   // watchdog: give up well past the slowest correct run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      sb           = new();
      hold_request = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Disabled after reset: even a clear must be ignored.
      send_item(make_item(OP_CLEAR, 8'h00));
      send_item(make_item(OP_CHAR, 8'h41));
      wait_idle();

      // Directed walk on a 4 x 3 screen.
      set_config(1'b1, 9'd4, 9'd3);
      send_item(make_item(OP_CLEAR, 8'hFF));
      send_item(make_item(OP_CHAR, 8'h41));
      send_item(make_item(OP_CHAR, CHAR_SPACE));
      send_item(make_item(OP_CHAR, CHAR_PRINT_MAX));
      // non-printable at the last column: wrap without drawing
      send_item(make_item(OP_CHAR, 8'h7F));
      // backspace at column zero does nothing
      send_item(make_item(OP_CHAR, CHAR_BS));
      send_item(make_item(OP_CHAR, 8'h00));
      send_item(make_item(OP_CHAR, CHAR_BS));
      send_item(make_item(OP_CHAR, 8'h1F));
      send_item(make_item(OP_CHAR, 8'h80));
      send_item(make_item(OP_CHAR, CHAR_CR));
      send_item(make_item(OP_CHAR, CHAR_LF));
      // line feed on the last row scrolls
      send_item(make_item(OP_CHAR, CHAR_LF));
      // a full row of text: the last draw also wraps and scrolls
      send_item(make_item(OP_CHAR, 8'h5A));
      send_item(make_item(OP_CHAR, 8'h79));
      send_item(make_item(OP_CHAR, 8'h30));
      send_item(make_item(OP_CHAR, 8'h7E));
      send_item(make_item(OP_CHAR, 8'hFF));
      send_item(make_item(OP_CLEAR, CHAR_LF));
      wait_idle();

      // Hold the receiver off for a long stretch while items keep coming,
      // so the result buffer fills and the input stalls.
      set_config(1'b1, COLUMNS_RESET, ROWS_RESET);
      hold_request = 80;
      drive_items(40, MIX_TEXT, 0);
      wait_idle();

      // Full-size screen: run the column, then the row, toward their top values.
      set_config(1'b1, 9'd256, 9'd256);
      send_item(make_item(OP_CLEAR, 8'h00));
      drive_items(200, MIX_LONG_LINE, 3);
      wait_idle();
      drive_items(270, MIX_TALL, 3);
      wait_idle();

      // Shrink to zero sizes with the cursor far out: draws use the stored
      // cursor, the next advance wraps and scrolls back onto the screen.
      set_config(1'b1, 9'd0, 9'd0);
      drive_items(20, MIX_TEXT, 4);
      wait_idle();

      // Oversize values clamp to the limits.
      set_config(1'b1, 9'd511, 9'd3);
      drive_items(20, MIX_TEXT, 2);
      wait_idle();
      set_config(1'b1, 9'd1, 9'd511);
      drive_items(20, MIX_TEXT, 2);
      wait_idle();

      // Disabled again: noise goes nowhere.
      set_config(1'b0, 9'd5, 9'd5);
      drive_items(20, MIX_NOISE, 2);
      wait_idle();

      // Random screen sizes with ordinary text.
      for (int p = 0; p < 2; p++) begin
         set_config(1'b1, random_size(), random_size());
         drive_items(30, MIX_TEXT, 6);
         wait_idle();
      end

      // Random bytes and clears, no gaps.
      set_config(1'b1, 9'd7, 9'd4);
      drive_items(40, MIX_NOISE, 0);

      // Let the last commands drain, with a bound, then judge.
      req_valid <= 1'b0;
      for (int n = 0; n < 5000 && sb.pending() > 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending() > 0) sb.note_error("commands never delivered", 8'h00, 8'(sb.pending()));
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
